// ----- src/nfva_pkg.sv -----
`default_nettype none
package nfva_pkg;
	localparam int MaxIntervals = 64;
	localparam int ValueWidth = 32;
	localparam int AddrWidth = $clog2(MaxIntervals);
	localparam int CountWidth = $clog2(MaxIntervals + 1);
	localparam int EntryWidth = 2 * ValueWidth;

	typedef logic [ValueWidth-1:0] value_t;
	typedef logic [CountWidth-1:0] count_t;
	typedef logic [AddrWidth-1:0] addr_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_REQUEST = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CMP,
		S_DEC,
		S_SHUP_RD,
		S_SHUP_WR,
		S_SHDN_RD,
		S_SHDN_WR
	} fsm_t;
endpackage
`default_nettype wire

// ----- src/nfva_req_if.sv -----
`default_nettype none
interface nfva_req_if;
	logic valid;
	logic ready;
	logic operation;
	logic [nfva_pkg::ValueWidth-1:0] range_start;
	logic [nfva_pkg::ValueWidth-1:0] range_end;
	logic [nfva_pkg::ValueWidth-1:0] request_value;
	modport source (output valid, operation, range_start, range_end, request_value,
		input ready);
	modport sink (input valid, operation, range_start, range_end, request_value,
		output ready);
endinterface
`default_nettype wire

// ----- src/nfva_rsp_if.sv -----
`default_nettype none
interface nfva_rsp_if;
	logic valid;
	logic ready;
	logic [31:0] allocated_value;
	logic [1:0] status;
	modport source (output valid, allocated_value, status, input ready);
	modport sink (input valid, allocated_value, status, output ready);
endinterface
`default_nettype wire

// ----- src/nfva_ram.sv -----
`default_nettype none
module nfva_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- src/nearest_free_value_allocator_core.sv -----
`default_nettype none
// channel  | dir | payload
// req_ch   | in  | operation, range_start, range_end, request_value
// rsp_ch   | out | allocated_value, status
//
// one request at a time; a scanned entry passes a read and a compare state,
// a moved one a read and a write state; a load scans up to its slot and moves the rest up
// a value request scans, decides, then moves entries down when an interval is removed or
// up when one is split; a refused load or an empty-table request answers at once, and
// a refused split after the decision; one read and one write ram port, one compare per read
// reset clears the fsm, the result flag and the interval count only; the ram needs no clearing
// the result is held in an output register until rsp_ch.ready; req_ch.ready is low meanwhile
module nearest_free_value_allocator_core (
	input wire logic clk,
	input wire logic arst_n,
	nfva_req_if.sink req_ch,
	nfva_rsp_if.source rsp_ch
);
	nfva_pkg::fsm_t state_q, state_d;
	logic op_q, op_d;
	nfva_pkg::value_t a_q, a_d, b_q, b_d, x_q, x_d;
	nfva_pkg::value_t cur_s_q, cur_s_d, cur_e_q, cur_e_d;
	nfva_pkg::value_t prv_s_q, prv_s_d, prv_e_q, prv_e_d;
	logic have_cur_q, have_cur_d;
	nfva_pkg::count_t idx_q, idx_d, k_q, k_d, pos_q, pos_d, count_q, count_d;
	nfva_pkg::value_t val_q, val_d;
	logic [1:0] st_q, st_d;
	logic out_valid_q, out_valid_d;

	// ram port
	logic we;
	nfva_pkg::addr_t waddr, raddr;
	logic [nfva_pkg::EntryWidth-1:0] wdata, rdata;
	nfva_pkg::value_t rd_s, rd_e;

	nfva_ram #(.WIDTH(nfva_pkg::EntryWidth), .DEPTH(nfva_pkg::MaxIntervals)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign rd_s = rdata[nfva_pkg::EntryWidth-1:nfva_pkg::ValueWidth];
	assign rd_e = rdata[nfva_pkg::ValueWidth-1:0];

	logic accept, full, last_idx;
	assign req_ch.ready = (state_q == nfva_pkg::S_IDLE) && !out_valid_q;
	assign accept = req_ch.valid && req_ch.ready;
	assign full = (count_q == nfva_pkg::CountWidth'(nfva_pkg::MaxIntervals));
	assign last_idx = (idx_q + 1'b1 == count_q);

	// shared compare unit: one start compare per scanned entry
	logic scan_go_on;
	assign scan_go_on = (op_q == nfva_pkg::OP_LOAD) ? (rd_s <= a_q) : (rd_s < x_q);

	// decision for a value request once the scan has stopped
	logic hit, first, in_prev, at_end, near_low, use_low;
	nfva_pkg::value_t dist_lo, dist_hi;
	assign hit = have_cur_q && (cur_s_q == x_q);
	assign first = (idx_q == '0);
	assign in_prev = (x_q <= prv_e_q);
	assign at_end = (x_q == prv_e_q);
	assign dist_lo = x_q - prv_e_q;
	assign dist_hi = cur_s_q - x_q;
	assign near_low = dist_lo <= dist_hi;
	// take lowest value of interval idx
	assign use_low = hit || first || (!in_prev && have_cur_q && !near_low);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nfva_pkg::S_IDLE: begin
				if (accept) begin
					if (req_ch.operation == nfva_pkg::OP_LOAD) begin
						if (full) state_d = nfva_pkg::S_IDLE;
						else if (count_q == '0) state_d = nfva_pkg::S_SHUP_RD;
						else state_d = nfva_pkg::S_RD;
					end else begin
						state_d = (count_q == '0) ? nfva_pkg::S_IDLE : nfva_pkg::S_RD;
					end
				end
			end
			nfva_pkg::S_RD: state_d = nfva_pkg::S_CMP;
			nfva_pkg::S_CMP: begin
				if (scan_go_on && !last_idx) state_d = nfva_pkg::S_RD;
				else if (op_q == nfva_pkg::OP_LOAD) state_d = nfva_pkg::S_SHUP_RD;
				else state_d = nfva_pkg::S_DEC;
			end
			nfva_pkg::S_DEC: begin
				if (use_low) begin
					state_d = (cur_s_q == cur_e_q) ? nfva_pkg::S_SHDN_RD : nfva_pkg::S_IDLE;
				end else if (in_prev && !at_end) begin
					state_d = full ? nfva_pkg::S_IDLE : nfva_pkg::S_SHUP_RD;
				end else begin
					state_d = (prv_s_q == prv_e_q) ? nfva_pkg::S_SHDN_RD : nfva_pkg::S_IDLE;
				end
			end
			nfva_pkg::S_SHUP_RD: begin
				state_d = (k_q == pos_q) ? nfva_pkg::S_IDLE : nfva_pkg::S_SHUP_WR;
			end
			nfva_pkg::S_SHUP_WR: state_d = nfva_pkg::S_SHUP_RD;
			nfva_pkg::S_SHDN_RD: begin
				state_d = (k_q + 1'b1 >= count_q) ? nfva_pkg::S_IDLE : nfva_pkg::S_SHDN_WR;
			end
			nfva_pkg::S_SHDN_WR: state_d = nfva_pkg::S_SHDN_RD;
			default: state_d = nfva_pkg::S_IDLE;
		endcase
	end

	// datapath and ram control
	always_comb begin
		op_d = op_q;
		a_d = a_q;
		b_d = b_q;
		x_d = x_q;
		cur_s_d = cur_s_q;
		cur_e_d = cur_e_q;
		prv_s_d = prv_s_q;
		prv_e_d = prv_e_q;
		have_cur_d = have_cur_q;
		idx_d = idx_q;
		k_d = k_q;
		pos_d = pos_q;
		count_d = count_q;
		val_d = val_q;
		st_d = st_q;
		out_valid_d = out_valid_q;
		we = 1'b0;
		waddr = k_q[nfva_pkg::AddrWidth-1:0];
		wdata = rdata;
		raddr = idx_q[nfva_pkg::AddrWidth-1:0];
		if (out_valid_q && rsp_ch.ready) out_valid_d = 1'b0;
		case (state_q)
			nfva_pkg::S_IDLE: begin
				if (accept) begin
					op_d = req_ch.operation;
					// reversed bounds are swapped
					a_d = (req_ch.range_end < req_ch.range_start) ? req_ch.range_end
						: req_ch.range_start;
					b_d = (req_ch.range_end < req_ch.range_start) ? req_ch.range_start
						: req_ch.range_end;
					x_d = req_ch.request_value;
					idx_d = '0;
					k_d = count_q;
					pos_d = '0;
					have_cur_d = 1'b0;
					val_d = '0;
					st_d = nfva_pkg::ST_OK;
					if (req_ch.operation == nfva_pkg::OP_LOAD) begin
						if (full) begin
							st_d = nfva_pkg::ST_FULL;
							out_valid_d = 1'b1;
						end
					end else if (count_q == '0) begin
						st_d = nfva_pkg::ST_EMPTY;
						out_valid_d = 1'b1;
					end
				end
			end
			nfva_pkg::S_CMP: begin
				if (op_q == nfva_pkg::OP_LOAD) begin
					// equal starts go after the stored ones
					if (scan_go_on) begin
						idx_d = idx_q + 1'b1;
						if (last_idx) pos_d = count_q;
					end else begin
						pos_d = idx_q;
					end
					k_d = count_q;
				end else if (scan_go_on) begin
					prv_s_d = rd_s;
					prv_e_d = rd_e;
					idx_d = idx_q + 1'b1;
				end else begin
					cur_s_d = rd_s;
					cur_e_d = rd_e;
					have_cur_d = 1'b1;
				end
			end
			nfva_pkg::S_DEC: begin
				if (use_low) begin
					val_d = cur_s_q;
					k_d = idx_q;
					if (cur_s_q == cur_e_q) begin
						// interval used up, close the gap
					end else begin
						we = 1'b1;
						waddr = idx_q[nfva_pkg::AddrWidth-1:0];
						wdata = {cur_s_q + 1'b1, cur_e_q};
						out_valid_d = 1'b1;
					end
				end else if (in_prev && !at_end) begin
					if (full) begin
						st_d = nfva_pkg::ST_FULL;
						out_valid_d = 1'b1;
					end else begin
						// split: lower part stays, upper part inserted after it
						we = 1'b1;
						waddr = nfva_pkg::AddrWidth'(idx_q - 1'b1);
						wdata = {prv_s_q, x_q - 1'b1};
						a_d = x_q + 1'b1;
						b_d = prv_e_q;
						pos_d = idx_q;
						k_d = count_q;
						val_d = x_q;
					end
				end else begin
					val_d = prv_e_q;
					k_d = idx_q - 1'b1;
					if (prv_s_q != prv_e_q) begin
						we = 1'b1;
						waddr = nfva_pkg::AddrWidth'(idx_q - 1'b1);
						wdata = {prv_s_q, prv_e_q - 1'b1};
						out_valid_d = 1'b1;
					end
				end
			end
			nfva_pkg::S_SHUP_RD: begin
				raddr = nfva_pkg::AddrWidth'(k_q - 1'b1);
				if (k_q == pos_q) begin
					we = 1'b1;
					waddr = pos_q[nfva_pkg::AddrWidth-1:0];
					wdata = {a_q, b_q};
					count_d = count_q + 1'b1;
					out_valid_d = 1'b1;
				end
			end
			nfva_pkg::S_SHUP_WR: begin
				we = 1'b1;
				waddr = k_q[nfva_pkg::AddrWidth-1:0];
				k_d = k_q - 1'b1;
			end
			nfva_pkg::S_SHDN_RD: begin
				raddr = nfva_pkg::AddrWidth'(k_q + 1'b1);
				if (k_q + 1'b1 >= count_q) begin
					count_d = count_q - 1'b1;
					out_valid_d = 1'b1;
				end
			end
			nfva_pkg::S_SHDN_WR: begin
				we = 1'b1;
				waddr = k_q[nfva_pkg::AddrWidth-1:0];
				k_d = k_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nfva_pkg::S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		a_q <= a_d;
		b_q <= b_d;
		x_q <= x_d;
		cur_s_q <= cur_s_d;
		cur_e_q <= cur_e_d;
		prv_s_q <= prv_s_d;
		prv_e_q <= prv_e_d;
		have_cur_q <= have_cur_d;
		idx_q <= idx_d;
		k_q <= k_d;
		pos_q <= pos_d;
		val_q <= val_d;
		st_q <= st_d;
	end

	assign rsp_ch.valid = out_valid_q;
	assign rsp_ch.allocated_value = 32'(val_q);
	assign rsp_ch.status = st_q;

	// interval count never exceeds the table
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= nfva_pkg::CountWidth'(nfva_pkg::MaxIntervals))
		else $error("interval count overflow");

	// no new request while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !req_ch.ready)
		else $error("request taken while result pending");

	// count moves by at most one per cycle
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1)
		|| (count_q == $past(count_q) - 1'b1))
		else $error("interval count jumped");

	// a result only rises when the fsm returns to idle
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> state_q == nfva_pkg::S_IDLE)
		else $error("result raised mid sequence");
endmodule
`default_nettype wire

// ----- tb/sv/tb_nearest_free_value_allocator_core.sv -----
module tb_nearest_free_value_allocator_core;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		nfva_pkg::op_t op;
		nfva_pkg::value_t lo;
		nfva_pkg::value_t hi;
		nfva_pkg::value_t want;
	} request_t;

	typedef struct packed {
		nfva_pkg::value_t value;
		nfva_pkg::status_t status;
	} grant_t;

	logic clk;
	logic arst_n;

	nfva_req_if req_ch ();
	nfva_rsp_if rsp_ch ();

	nearest_free_value_allocator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_ch(req_ch.sink),
		.rsp_ch(rsp_ch.source)
	);

	// free-list model: sorted intervals kept in queues
	nfva_pkg::value_t free_lo[$];
	nfva_pkg::value_t free_hi[$];
	grant_t grant_q[$];

	int mismatch_count;
	int cycle_count;
	bit fill_mode;
	bit hold_active;
	bit run_done;
	int burst_left;
	int gap_left;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// hand out the low end of an interval, dropping it when used up
	function automatic nfva_pkg::value_t grant_low(int p);
		nfva_pkg::value_t v;
		v = free_lo[p];
		if (v == free_hi[p]) begin
			free_lo.delete(p);
			free_hi.delete(p);
		end else
			free_lo[p] = v + 1'b1;
		return v;
	endfunction

	function automatic nfva_pkg::value_t grant_high(int p);
		nfva_pkg::value_t v;
		v = free_hi[p];
		if (v == free_lo[p]) begin
			free_lo.delete(p);
			free_hi.delete(p);
		end else
			free_hi[p] = v - 1'b1;
		return v;
	endfunction

	function automatic grant_t predict_grant(request_t r);
		grant_t g;
		nfva_pkg::value_t s, e, x, pe;
		int i, p, n;
		g.value = '0;
		g.status = nfva_pkg::ST_OK;
		n = free_lo.size();
		if (r.op == nfva_pkg::OP_LOAD) begin
			s = r.lo;
			e = r.hi;
			if (e < s) begin
				s = r.hi;
				e = r.lo;
			end
			if (n >= nfva_pkg::MaxIntervals)
				g.status = nfva_pkg::ST_FULL;
			else begin
				// equal starts go after the stored ones
				i = 0;
				while (i < n && free_lo[i] <= s) i++;
				free_lo.insert(i, s);
				free_hi.insert(i, e);
			end
		end else if (n == 0)
			g.status = nfva_pkg::ST_EMPTY;
		else begin
			x = r.want;
			i = 0;
			while (i < n && free_lo[i] < x) i++;
			if (i < n && free_lo[i] == x)
				g.value = grant_low(i);
			else if (i == 0)
				g.value = grant_low(0);
			else begin
				p = i - 1;
				pe = free_hi[p];
				if (x <= pe) begin
					if (x == pe)
						g.value = grant_high(p);
					else if (n >= nfva_pkg::MaxIntervals)
						g.status = nfva_pkg::ST_FULL;
					else begin
						// split around the wanted value
						free_hi[p] = x - 1'b1;
						free_lo.insert(p + 1, x + 1'b1);
						free_hi.insert(p + 1, pe);
						g.value = x;
					end
				end else if (i >= n)
					g.value = grant_high(p);
				else if (x - pe <= free_lo[i] - x)
					g.value = grant_high(p);
				else
					g.value = grant_low(i);
			end
		end
		return g;
	endfunction

	// one request, with bursty source timing unless in fill mode
	task automatic send_request(request_t r);
		if (!fill_mode) begin
			if (burst_left == 0) begin
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				burst_left = $urandom_range(1, 12);
			end
			while (gap_left > 0) begin
				@(negedge clk);
				gap_left--;
			end
			burst_left--;
		end
		req_ch.valid = 1'b1;
		req_ch.operation = r.op;
		req_ch.range_start = r.lo;
		req_ch.range_end = r.hi;
		req_ch.request_value = r.want;
		do @(posedge clk); while (!req_ch.ready);
		grant_q = {grant_q, predict_grant(r)};
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	task automatic load_range(nfva_pkg::value_t lo, nfva_pkg::value_t hi);
		request_t r;
		r.op = nfva_pkg::OP_LOAD;
		r.lo = lo;
		r.hi = hi;
		r.want = nfva_pkg::value_t'($urandom);
		send_request(r);
	endtask

	task automatic ask_value(nfva_pkg::value_t x);
		request_t r;
		r.op = nfva_pkg::OP_REQUEST;
		r.lo = nfva_pkg::value_t'($urandom);
		r.hi = nfva_pkg::value_t'($urandom);
		r.want = x;
		send_request(r);
	endtask

	task automatic wait_drained();
		while (grant_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// drain the table with low requests so the next test starts empty
	task automatic empty_table();
		while (free_lo.size() != 0) ask_value('0);
	endtask

	// empty table, value extremes, swapped bounds, equal starts, overlap
	task automatic test_directed();
		ask_value(32'h1234);
		load_range(32'd100, 32'd110);
		load_range(32'd50, 32'd40);
		load_range(32'd100, 32'd100);
		load_range(32'hFFFF_FFF0, 32'hFFFF_FFFF);
		load_range(32'd0, 32'd0);
		load_range(32'd45, 32'd60);
		ask_value(32'd0);
		ask_value(32'd105);
		ask_value(32'd110);
		ask_value(32'd100);
		ask_value(32'hFFFF_FFFF);
		ask_value(32'd80);
		ask_value(32'd75);
		ask_value(32'd1000);
		ask_value(32'd30);
		ask_value(32'h8000_0000);
		empty_table();
		ask_value(32'hFFFF_FFFF);
		wait_drained();
	endtask

	// full table: refused load, refused split, end takes still allowed
	task automatic test_full_table();
		int k;
		// short intervals keep the drain cheap, the third one is wide enough to split
		for (k = 0; k < nfva_pkg::MaxIntervals; k++) begin
			if (k == 2)
				load_range(nfva_pkg::value_t'(k * 100), nfva_pkg::value_t'(k * 100 + 10));
			else
				load_range(nfva_pkg::value_t'(k * 100), nfva_pkg::value_t'(k * 100 + 1));
		end
		load_range(32'd7, 32'd9);
		ask_value(32'd205);
		ask_value(32'd200);
		ask_value(32'd6310);
		ask_value(32'd205);
		load_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_drained();
		empty_table();
		wait_drained();
	endtask

	// block fills while the sink holds off
	task automatic test_backpressure();
		int k;
		nfva_pkg::value_t a;
		fill_mode = 1'b1;
		for (k = 0; k < 20; k++) begin
			a = nfva_pkg::value_t'($urandom_range(0, 5000));
			load_range(a, a + nfva_pkg::value_t'($urandom_range(0, 3)));
			ask_value(nfva_pkg::value_t'($urandom_range(0, 5000)));
		end
		fill_mode = 1'b0;
		wait_drained();
		empty_table();
		wait_drained();
	endtask

	function automatic nfva_pkg::value_t pick_value(int span);
		case ($urandom_range(0, 5))
			0: return nfva_pkg::value_t'($urandom);
			1: return nfva_pkg::value_t'(32'hFFFF_FFFF - $urandom_range(0, span));
			default: return nfva_pkg::value_t'($urandom_range(0, span));
		endcase
	endfunction

	// mostly small dense ranges so requests hit every search case
	task automatic test_random();
		int k, span;
		nfva_pkg::value_t a;
		span = 2000;
		for (k = 0; k < 1500; k++) begin
			if (k % 300 == 0) span = (span == 2000) ? 200 : 2000;
			if ($urandom_range(0, 99) < ((free_lo.size() < 8) ? 60 : 35)) begin
				a = pick_value(span);
				if ($urandom_range(0, 9) == 0)
					load_range(nfva_pkg::value_t'($urandom), nfva_pkg::value_t'($urandom));
				else
					load_range(a, a + nfva_pkg::value_t'($urandom_range(0, 20)));
			end else
				ask_value(pick_value(span));
		end
		wait_drained();
	endtask

	// long sink hold-off while the source keeps sending
	initial begin
		hold_active = 1'b0;
		wait (fill_mode);
		@(negedge clk);
		hold_active = 1'b1;
		repeat (300) @(negedge clk);
		hold_active = 1'b0;
	end

	// sink stall pattern plus the long hold-off
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else if (hold_active)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ((cycle_count / 64) % 3 == 0) ? 1'b1 :
				($urandom_range(0, 3) != 0);
	end

	// compare each accepted grant with the oldest prediction
	always @(posedge clk) begin
		grant_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (grant_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected grant value=%h status=%0d",
						rsp_ch.allocated_value, rsp_ch.status);
			end else begin
				want = grant_q.pop_front();
				if (rsp_ch.allocated_value !== want.value || rsp_ch.status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("grant mismatch: expected value=%h status=%0d, got value=%h status=%0d",
							want.value, want.status, rsp_ch.allocated_value, rsp_ch.status);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000 && !run_done) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		fill_mode = 1'b0;
		run_done = 1'b0;
		burst_left = 0;
		gap_left = 0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = nfva_pkg::OP_LOAD;
		req_ch.range_start = '0;
		req_ch.range_end = '0;
		req_ch.request_value = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_full_table();
		test_backpressure();
		test_random();
		repeat (20) @(negedge clk);
		run_done = 1'b1;
		if (mismatch_count == 0 && grant_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
